FILE: design/ftw_pkg.sv
// shared types, codes and constants of the four-level page table walker
// no dependencies; every other file of the block imports this package
package ftw_pkg;

  localparam int VA_W           = 48;
  localparam int PA_W           = 52;
  localparam int FLAG_W         = 12;
  localparam int ENTRY_W        = 64;
  localparam int IDX_W          = 9;
  localparam int LEVELS         = 4;
  localparam int PAGE_SHIFT     = 12;
  localparam int HUGE_SHIFT     = 21;
  localparam int NUM_TABLES_DEF = 64;
  localparam int ENTRIES_PER_TABLE = 1 << IDX_W;

  // operation codes
  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_MAP       = 2'd1;
  localparam logic [1:0] OP_UNMAP     = 2'd2;
  localparam logic [1:0] OP_RSVD      = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;

  // entry flag positions
  localparam int FLAG_PRESENT_BIT = 0;
  localparam int FLAG_HUGE_BIT    = 7;
  localparam logic [FLAG_W-1:0] PTR_FLAGS = 12'h003;  // present and writable

  typedef struct packed {
    logic [1:0]        op;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr_in;
    logic [FLAG_W-1:0] entry_flags;
  } walk_req_t;

  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    logic [1:0]      status;
  } walk_res_t;

  // 9-bit table index of a level, level 0 is the root
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    idx = va[PAGE_SHIFT + IDX_W * (LEVELS - 1 - int'(lvl)) +: IDX_W];
    return idx;
  endfunction

endpackage

FILE: design/ftw_if.sv
// valid/ready channels of the page table walker: request and response
// depends on ftw_pkg for field widths
interface ftw_in_if import ftw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [VA_W-1:0]   virt_addr;
  logic [PA_W-1:0]   phys_addr_in;
  logic [FLAG_W-1:0] entry_flags;

  modport source (output valid, op, virt_addr, phys_addr_in, entry_flags, input ready);
  modport sink   (input valid, op, virt_addr, phys_addr_in, entry_flags, output ready);
endinterface

interface ftw_out_if import ftw_pkg::*;;
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] phys_addr_out;
  logic [1:0]      status;

  modport source (output valid, phys_addr_out, status, input ready);
  modport sink   (input valid, phys_addr_out, status, output ready);
endinterface

FILE: design/ftw_table_ram.sv
// single-port table store, one access a cycle, registered read data
// depends on ftw_pkg for the entry width
module ftw_table_ram import ftw_pkg::*; #(
  parameter int  DEPTH  = NUM_TABLES_DEF * ENTRIES_PER_TABLE,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [ENTRY_W-1:0] wdata,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/ftw_walk_seq.sv
// walk sequencer: clears the store after reset, then walks up to four levels per item
// depends on ftw_pkg; drives the single port of ftw_table_ram
module ftw_walk_seq import ftw_pkg::*; #(
  parameter int  NUM_TABLES = NUM_TABLES_DEF,
  localparam int TBL_W      = $clog2(NUM_TABLES),
  localparam int CNT_W      = $clog2(NUM_TABLES + 1),
  localparam int ADDR_W     = TBL_W + IDX_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  walk_req_t          req,
  output logic               res_valid,
  input  logic               res_take,
  output walk_res_t          res,
  output logic               ram_we,
  output logic [ADDR_W-1:0]  ram_addr,
  output logic [ENTRY_W-1:0] ram_wdata,
  input  logic [ENTRY_W-1:0] ram_rdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_TABLES * ENTRIES_PER_TABLE - 1);
  localparam logic [1:0]        LAST_LVL  = 2'(LEVELS - 1);
  localparam logic [1:0]        DIR_LVL   = 2'(LEVELS - 2);

  logic [2:0]        state, state_next;
  logic [1:0]        level, level_next;
  logic [TBL_W-1:0]  tbl, tbl_next;
  logic [CNT_W-1:0]  free_cnt, free_cnt_next;
  logic [ADDR_W-1:0] clr_addr;
  walk_req_t         cur;
  walk_res_t         res_r, res_next;

  logic [ADDR_W-1:0] cur_addr;
  logic [PA_W-1:0]   ptr;
  logic              present;
  logic              huge;
  logic              ptr_ok;
  logic              free_full;

  assign cur_addr  = {tbl, level_index(cur.virt_addr, level)};
  assign ptr       = ram_rdata[ENTRY_W-1:PAGE_SHIFT];
  assign present   = ram_rdata[FLAG_PRESENT_BIT];
  assign huge      = ram_rdata[FLAG_HUGE_BIT];
  assign ptr_ok    = ptr < PA_W'(NUM_TABLES);
  assign free_full = free_cnt == CNT_W'(NUM_TABLES);
  assign res       = res_r;

  always_comb begin
    state_next    = state;
    level_next    = level;
    tbl_next      = tbl;
    free_cnt_next = free_cnt;
    res_next      = res_r;
    ram_we        = 1'b0;
    ram_addr      = cur_addr;
    ram_wdata     = '0;
    req_ready     = 1'b0;
    res_valid     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          level_next = '0;
          tbl_next   = '0;
          res_next   = '{phys_addr: '0, status: ST_DONE};
          state_next = (req.op == OP_RSVD) ? S_RESP : S_READ;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_RESP;
        unique case (cur.op)
          OP_TRANSLATE: begin
            if (!present) begin
              res_next.status = ST_ABSENT;
            end else if (level == LAST_LVL) begin
              res_next.phys_addr = {ram_rdata[PA_W-1:PAGE_SHIFT],
                                    cur.virt_addr[PAGE_SHIFT-1:0]};
            end else if (level == DIR_LVL && huge) begin
              res_next.phys_addr = {ram_rdata[PA_W-1:HUGE_SHIFT],
                                    cur.virt_addr[HUGE_SHIFT-1:0]};
            end else if (!ptr_ok) begin
              res_next.status = ST_ABSENT;
            end else begin
              tbl_next   = ptr[TBL_W-1:0];
              level_next = level + 2'd1;
              state_next = S_READ;
            end
          end
          OP_MAP: begin
            if (level == LAST_LVL) begin
              // leaf: page frame and caller flags, present or not
              ram_we    = 1'b1;
              ram_wdata = {{(ENTRY_W - PA_W){1'b0}}, cur.phys_addr_in[PA_W-1:PAGE_SHIFT],
                           cur.entry_flags};
            end else if (present) begin
              if (ptr_ok) begin
                tbl_next   = ptr[TBL_W-1:0];
                level_next = level + 2'd1;
                state_next = S_READ;
              end else begin
                res_next.status = ST_ABSENT;
              end
            end else if (free_full) begin
              res_next.status = ST_NOFREE;
            end else begin
              // allocate the next table and link it in
              ram_we        = 1'b1;
              ram_wdata     = {{(ENTRY_W - PAGE_SHIFT - TBL_W){1'b0}}, free_cnt[TBL_W-1:0],
                               cur.entry_flags | PTR_FLAGS};
              free_cnt_next = free_cnt + 1'b1;
              tbl_next      = free_cnt[TBL_W-1:0];
              level_next    = level + 2'd1;
              state_next    = S_READ;
            end
          end
          OP_UNMAP: begin
            if (level == LAST_LVL) begin
              ram_we = 1'b1;
            end else if (present && ptr_ok) begin
              tbl_next   = ptr[TBL_W-1:0];
              level_next = level + 2'd1;
              state_next = S_READ;
            end else begin
              res_next.status = ST_ABSENT;
            end
          end
          default: begin
            res_next.status = ST_DONE;
          end
        endcase
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      free_cnt <= CNT_W'(1);
      level    <= '0;
      tbl      <= '0;
    end else begin
      state    <= state_next;
      free_cnt <= free_cnt_next;
      level    <= level_next;
      tbl      <= tbl_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_next;
    if (state == S_IDLE && req_valid) begin
      cur <= req;
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= CNT_W'(NUM_TABLES) && free_cnt != '0)
    else $error("table allocation counter out of range");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_EVAL))
    else $error("table store written outside clear or evaluate");

  a_alloc_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && free_cnt != $past(free_cnt)) |->
      (free_cnt == $past(free_cnt) + 1'b1 && $past(state) == S_EVAL && $past(cur.op) == OP_MAP))
    else $error("allocation counter moved other than by one map step");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_READ || state == S_RESP))
    else $error("accepted item did not start a walk");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> (res_valid && $stable(res_r)))
    else $error("pending result changed before it was taken");

endmodule

FILE: design/four_level_page_table_walker.sv
// top level of the four-level page table walker: output register and handshakes
// depends on ftw_pkg, ftw_if, ftw_walk_seq and ftw_table_ram
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    op, virt_addr, phys_addr_in, entry_flags
//   rsp      out  valid/ready    phys_addr_out, status
//
// walk: each level walked is a store read, then an evaluate, set by the single
//   table store port and its registered read data; a full walk's result is
//   registered in the sequencer, and the next item is taken once that result
//   has moved to rsp; op 3 skips the walk and goes straight to its result
// reset: after rst the store is cleared one entry a cycle, all NUM_TABLES*512
//   entries (32768 at the default), and req.ready stays low meanwhile
// stalls: a finished result waits in the rsp register while the next item is
//   accepted; a second result waits in the sequencer until rsp drains
module four_level_page_table_walker import ftw_pkg::*; #(
  parameter int NUM_TABLES = NUM_TABLES_DEF
) (
  input logic     clk,
  input logic     rst,
  ftw_in_if.sink    req,
  ftw_out_if.source rsp
);

  localparam int DEPTH  = NUM_TABLES * ENTRIES_PER_TABLE;
  localparam int ADDR_W = $clog2(DEPTH);

  walk_req_t          req_item;
  walk_res_t          res_item;
  logic               res_valid;
  logic               res_take;
  logic               out_valid;
  walk_res_t          out_item;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // pack the incoming item
  assign req_item = '{op:           req.op,
                      virt_addr:    req.virt_addr,
                      phys_addr_in: req.phys_addr_in,
                      entry_flags:  req.entry_flags};

  ftw_walk_seq #(
    .NUM_TABLES (NUM_TABLES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req       (req_item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res_item),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  ftw_table_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // result moves into the output register when it is empty or draining
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item <= res_item;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.phys_addr_out = out_item.phys_addr;
  assign rsp.status        = out_item.status;

endmodule

FILE: tb/tb_four_level_page_table_walker.sv
// self-checking testbench of four_level_page_table_walker: directed walks, then random ones
// depends on ftw_pkg, ftw_in_if, ftw_out_if and the walker rtl
module tb_four_level_page_table_walker;
  import ftw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TBL      = NUM_TABLES_DEF;
  localparam int IDLE_PCT     = 16;
  localparam int RAND_ITEMS   = 1675;
  // no idling on either side while the random item count is in this window
  localparam int CALM_FROM    = 1000;
  localparam int CALM_TO      = 1300;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = 20;
  // limit on the run length, which includes the store clear after reset
  localparam int CYCLE_LIMIT  = 400_000;
  localparam logic [ENTRY_W-1:0] PAGE_OFS = 64'h0000_0000_0000_0FFF;
  localparam logic [ENTRY_W-1:0] HUGE_OFS = 64'h0000_0000_001F_FFFF;

  // one row of the directed table; res is only used when known is set
  typedef struct {
    walk_req_t item;
    bit        known;
    walk_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic calm;

  ftw_in_if  req_if ();
  ftw_out_if rsp_if ();

  four_level_page_table_walker #(
    .NUM_TABLES(NUM_TBL)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // shadow copy of the page tables and the table allocator
  logic [ENTRY_W-1:0] pt_store [NUM_TBL * ENTRIES_PER_TABLE];
  int unsigned        alloc_next;

  // results still owed by the walker, oldest first
  walk_res_t walk_results_due [$];

  int unsigned cycle_cnt = 0;
  int unsigned bad_cnt   = 0;
  int unsigned n_checked = 0;
  int unsigned n_maps    = 0;
  int unsigned n_nofree  = 0;
  int unsigned n_hits    = 0;
  int unsigned n_misses  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // walks the shadow tables for one item, updates them and returns the result
  function automatic walk_res_t walk_predict(input walk_req_t it);
    walk_res_t          res;
    logic [IDX_W-1:0]   idx [LEVELS];
    logic [ENTRY_W-1:0] ent;
    logic [ENTRY_W-1:0] sum;
    int unsigned        tbl;
    int unsigned        s;
    bit                 stop;
    res        = '0;
    res.status = ST_DONE;
    tbl        = 0;
    stop       = 1'b0;
    // level 0 takes bits 47..39, level 3 bits 20..12
    for (int l = 0; l < LEVELS; l++)
      idx[l] = it.virt_addr[PAGE_SHIFT + IDX_W * (LEVELS - 1 - l) +: IDX_W];
    case (it.op)
      OP_TRANSLATE: begin
        for (int l = 0; l < LEVELS - 1 && !stop; l++) begin
          ent = pt_store[tbl * ENTRIES_PER_TABLE + idx[l]];
          if (!ent[FLAG_PRESENT_BIT]) begin
            res.status = ST_ABSENT;
            stop       = 1'b1;
          end else if (l == LEVELS - 2 && ent[FLAG_HUGE_BIT]) begin
            // 2 MiB page at the directory level
            sum           = (ent & ~HUGE_OFS) + ENTRY_W'(it.virt_addr[HUGE_SHIFT-1:0]);
            res.phys_addr = sum[PA_W-1:0];
            stop          = 1'b1;
          end else if ((ent >> PAGE_SHIFT) >= NUM_TBL) begin
            res.status = ST_ABSENT;
            stop       = 1'b1;
          end else begin
            tbl = int'(ent >> PAGE_SHIFT);
          end
        end
        if (!stop) begin
          ent = pt_store[tbl * ENTRIES_PER_TABLE + idx[LEVELS-1]];
          if (!ent[FLAG_PRESENT_BIT]) begin
            res.status = ST_ABSENT;
          end else begin
            sum           = (ent & ~PAGE_OFS) + ENTRY_W'(it.virt_addr[PAGE_SHIFT-1:0]);
            res.phys_addr = sum[PA_W-1:0];
          end
        end
      end
      OP_MAP: begin
        for (int l = 0; l < LEVELS - 1 && !stop; l++) begin
          s = tbl * ENTRIES_PER_TABLE + idx[l];
          if (!pt_store[s][FLAG_PRESENT_BIT]) begin
            if (alloc_next >= NUM_TBL) begin
              // out of tables, levels written so far stay
              res.status = ST_NOFREE;
              stop       = 1'b1;
            end else begin
              pt_store[s] = (ENTRY_W'(alloc_next) << PAGE_SHIFT) | ENTRY_W'(PTR_FLAGS) |
                            ENTRY_W'(it.entry_flags);
              alloc_next++;
            end
          end
          // a present directory entry is followed as a pointer even when huge
          if (!stop) begin
            if ((pt_store[s] >> PAGE_SHIFT) >= NUM_TBL) begin
              res.status = ST_ABSENT;
              stop       = 1'b1;
            end else begin
              tbl = int'(pt_store[s] >> PAGE_SHIFT);
            end
          end
        end
        if (!stop)
          pt_store[tbl * ENTRIES_PER_TABLE + idx[LEVELS-1]] =
            {{(ENTRY_W - PA_W){1'b0}}, it.phys_addr_in[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} |
            ENTRY_W'(it.entry_flags);
      end
      OP_UNMAP: begin
        for (int l = 0; l < LEVELS - 1 && !stop; l++) begin
          ent = pt_store[tbl * ENTRIES_PER_TABLE + idx[l]];
          if (!ent[FLAG_PRESENT_BIT] || (ent >> PAGE_SHIFT) >= NUM_TBL) begin
            res.status = ST_ABSENT;
            stop       = 1'b1;
          end else begin
            tbl = int'(ent >> PAGE_SHIFT);
          end
        end
        if (!stop)
          pt_store[tbl * ENTRIES_PER_TABLE + idx[LEVELS-1]] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // a table index from a small pool, so random walks share tables
  function automatic logic [IDX_W-1:0] pick_slot();
    case ($urandom_range(3))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd256;
      default: return 9'd511;
    endcase
  endfunction

  function automatic walk_req_t rand_walk();
    walk_req_t   it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)      it.op = OP_MAP;
    else if (pick < 72) it.op = OP_TRANSLATE;
    else if (pick < 95) it.op = OP_UNMAP;
    else                it.op = OP_RSVD;
    it.virt_addr    = VA_W'({$urandom, $urandom});
    it.phys_addr_in = PA_W'({$urandom, $urandom});
    it.entry_flags  = FLAG_W'($urandom);
    // most walks stay inside a few regions so mapped pages get revisited
    // and the table supply lasts a while before it runs dry
    if ($urandom_range(15) != 0) begin
      it.virt_addr[47:39] = pick_slot();
      it.virt_addr[38:30] = pick_slot();
      it.virt_addr[29:21] = pick_slot();
      it.virt_addr[20:12] = ($urandom_range(7) == 0) ? 9'd511 : IDX_W'($urandom_range(15));
    end
    // most maps leave a present leaf behind
    if (it.op == OP_MAP && $urandom_range(4) != 0)
      it.entry_flags[FLAG_PRESENT_BIT] = 1'b1;
    return it;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] op, input logic [VA_W-1:0] va,
                                      input logic [PA_W-1:0] pa, input logic [FLAG_W-1:0] fl,
                                      input bit known, input logic [1:0] st,
                                      input logic [PA_W-1:0] pa_out);
    dir_row_t r;
    r.item.op           = op;
    r.item.virt_addr    = va;
    r.item.phys_addr_in = pa;
    r.item.entry_flags  = fl;
    r.known             = known;
    r.res.phys_addr     = pa_out;
    r.res.status        = st;
    return r;
  endfunction

  // presents one item, waits for its handshake and books the result it owes
  task automatic send_item(input walk_req_t it, input bit known, input walk_res_t known_res);
    walk_res_t pred;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= it.op;
    req_if.virt_addr    <= it.virt_addr;
    req_if.phys_addr_in <= it.phys_addr_in;
    req_if.entry_flags  <= it.entry_flags;
    do @(posedge clk); while (!req_if.ready);
    pred = walk_predict(it);
    walk_results_due.push_back(known ? known_res : pred);
    if (it.op == OP_MAP) begin
      n_maps++;
      if (pred.status == ST_NOFREE) n_nofree++;
    end else if (it.op == OP_TRANSLATE) begin
      if (pred.status == ST_DONE) n_hits++;
      else                        n_misses++;
    end
  endtask

  // holds the request side off until every owed result has come back
  task automatic drain_walks();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (walk_results_due.size() != 0) @(posedge clk);
  endtask

  // response side: random back-pressure except in the calm window
  always @(posedge clk)
    rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin : rsp_check
    walk_res_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (walk_results_due.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= MAX_REPORTS)
          $display("[%0t] result with nothing due: pa %h status %0d",
                   $time, rsp_if.phys_addr_out, rsp_if.status);
      end else begin
        want = walk_results_due.pop_front();
        n_checked++;
        if (rsp_if.phys_addr_out !== want.phys_addr || rsp_if.status !== want.status) begin
          bad_cnt++;
          if (bad_cnt <= MAX_REPORTS)
            $display("[%0t] result %0d: pa %h status %0d, expected pa %h status %0d",
                     $time, n_checked, rsp_if.phys_addr_out, rsp_if.status,
                     want.phys_addr, want.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_cnt, walk_results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stim
    dir_row_t rows [$];
    rst                 = 1'b1;
    calm                = 1'b0;
    req_if.valid        = 1'b0;
    req_if.op           = OP_TRANSLATE;
    req_if.virt_addr    = '0;
    req_if.phys_addr_in = '0;
    req_if.entry_flags  = '0;
    rsp_if.ready        = 1'b0;
    foreach (pt_store[i]) pt_store[i] = '0;
    alloc_next = 1;

    // empty tables right after reset
    rows.push_back(mk_row(OP_TRANSLATE, 48'h0, 52'h0, 12'h000, 1'b1, ST_ABSENT, 52'h0));
    rows.push_back(mk_row(OP_UNMAP, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h000, 1'b1, ST_ABSENT, 52'h0));
    // reserved op with every field at its top
    rows.push_back(mk_row(OP_RSVD, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF,
                          1'b1, ST_DONE, 52'h0));
    // lowest page mapped to the highest frame, then read back with the top offset
    rows.push_back(mk_row(OP_MAP, 48'h0, 52'hF_FFFF_FFFF_FFFF, 12'h003, 1'b1, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_TRANSLATE, 48'h0000_0000_0FFF, 52'h0, 12'h000,
                          1'b1, ST_DONE, 52'hF_FFFF_FFFF_FFFF));
    // top page with all flags set: its directory entry comes out huge
    rows.push_back(mk_row(OP_MAP, 48'hFFFF_FFFF_FFFF, 52'h0, 12'hFFF, 1'b1, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h000, 1'b0, ST_DONE, 52'h0));
    // leaf written without the present flag is a miss
    rows.push_back(mk_row(OP_MAP, 48'h0000_0000_1000, 52'h0_0000_ABCD_E123, 12'h002,
                          1'b1, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_TRANSLATE, 48'h0000_0000_1234, 52'h0, 12'h000,
                          1'b1, ST_ABSENT, 52'h0));
    // unmap clears the leaf whenever the path is there, present leaf or not
    rows.push_back(mk_row(OP_UNMAP, 48'h0000_0000_1000, 52'h0, 12'h000, 1'b1, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_UNMAP, 48'h0, 52'h0, 12'h000, 1'b1, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_TRANSLATE, 48'h0, 52'h0, 12'h000, 1'b1, ST_ABSENT, 52'h0));
    rows.push_back(mk_row(OP_UNMAP, 48'h0, 52'h0, 12'h000, 1'b1, ST_DONE, 52'h0));
    // missing entry at the second level, then at the root
    rows.push_back(mk_row(OP_TRANSLATE, 48'h0000_4000_0000, 52'h0, 12'h000,
                          1'b1, ST_ABSENT, 52'h0));
    rows.push_back(mk_row(OP_TRANSLATE, 48'h8000_0000_0000, 52'h0, 12'h000,
                          1'b1, ST_ABSENT, 52'h0));
    rows.push_back(mk_row(OP_UNMAP, 48'h8000_0000_0000, 52'h0, 12'h000, 1'b1, ST_ABSENT, 52'h0));
    // one new table at the directory level only
    rows.push_back(mk_row(OP_MAP, 48'h0000_0020_0000, 52'h0_0012_3456_7000, 12'h001,
                          1'b1, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_TRANSLATE, 48'h0000_0020_0ABC, 52'h0, 12'h000,
                          1'b0, ST_DONE, 52'h0));
    // alternating bit patterns on every field
    rows.push_back(mk_row(OP_MAP, 48'h5555_5555_5555, 52'hA_AAAA_AAAA_AAAA, 12'h555,
                          1'b0, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_TRANSLATE, 48'h5555_5555_5555, 52'h0, 12'h000,
                          1'b0, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_MAP, 48'hAAAA_AAAA_AAAA, 52'h5_5555_5555_5555, 12'hAAA,
                          1'b0, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_TRANSLATE, 48'hAAAA_AAAA_AAAA, 52'h0, 12'h000,
                          1'b0, ST_DONE, 52'h0));
    // map and unmap go through the huge directory entry as a pointer,
    // translate still stops at it
    rows.push_back(mk_row(OP_MAP, 48'hFFFF_FFFF_E000, 52'h0_0000_0001_2000, 12'h003,
                          1'b1, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_TRANSLATE, 48'hFFFF_FFFF_E000, 52'h0, 12'h000,
                          1'b0, ST_DONE, 52'h0));
    rows.push_back(mk_row(OP_UNMAP, 48'hFFFF_FFFF_E000, 52'h0, 12'h000, 1'b1, ST_DONE, 52'h0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // ready stays low while the store is cleared, send_item just waits
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].res);
    drain_walks();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm <= (n >= CALM_FROM && n < CALM_TO);
      // let the walker run completely dry once in the middle
      if (n == RAND_ITEMS / 2) drain_walks();
      send_item(rand_walk(), 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    while (walk_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d walks checked: %0d maps (%0d out of tables), %0d translate hits, %0d misses",
             n_checked, n_maps, n_nofree, n_hits, n_misses);
    $display("%0d of %0d page tables allocated, %0d bad results", alloc_next, NUM_TBL, bad_cnt);
    if (bad_cnt == 0 && walk_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
